@@ hw/rtl/indexed_block_allocator_core_defines.svh @@
// ---------------------------------------------------------------------------
// Indexed block allocator assertion macros
// Concurrent property checks for simulation; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define IBA_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("iba: same-cycle check failed");
// Check that cons holds in the cycle after ante
`define IBA_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("iba: next-cycle check failed");
`else
`define IBA_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define IBA_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

@@ hw/rtl/iba_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed block allocator package
// Word types, status codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
package iba_pkg;

  // Field widths
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 6;
  localparam int STS_W  = 3;
  localparam int FNUM_W = 8;

  // Default sizes
  localparam int DISK_BLOCKS_DEF     = 1024;
  localparam int MAX_FILES_DEF       = 256;
  localparam int MAX_FILE_BLOCKS_DEF = 63;

  // Reset value of the managed block count
  localparam int BLOCKS_IN_USE_RST = 1024;

  // Result status codes
  localparam logic [STS_W-1:0] STS_GRANTED = 3'd0;
  localparam logic [STS_W-1:0] STS_INVALID = 3'd1;
  localparam logic [STS_W-1:0] STS_NOSPACE = 3'd2;
  localparam logic [STS_W-1:0] STS_FULL    = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY   = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] index_block;
    logic [CNT_W-1:0] block_count;
  } in_word_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [IDX_W-1:0]  block_number;
    logic [FNUM_W-1:0] file_number;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_GRANT,
    ST_RESP
  } state_t;

endpackage

@@ hw/rtl/indexed_block_allocator_core.sv @@
`timescale 1ns / 1ps
// Per request: the index block is read as the word is taken and then checked; a scan
// counts the free blocks below the managed block count and, if enough are found, a
// second pass grants them, one result word per granted block. Both passes walk the
// single read port of the block-use RAM one address per cycle; the grant pass holds
// while the output stalls.
// Reset: a clear pass writes every RAM entry free, with the input stalled.
// ---------------------------------------------------------------------------
// Indexed block allocator core
// First-fit allocator of disk blocks over a block-use map held in RAM.
// ---------------------------------------------------------------------------
`include "indexed_block_allocator_core_defines.svh"

module indexed_block_allocator_core #(
  parameter int DISK_BLOCKS     = iba_pkg::DISK_BLOCKS_DEF,
  parameter int MAX_FILES       = iba_pkg::MAX_FILES_DEF,
  parameter int MAX_FILE_BLOCKS = iba_pkg::MAX_FILE_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [iba_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  iba_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output iba_pkg::out_word_t             out_word
);

  import iba_pkg::*;

  localparam int AW = $clog2(DISK_BLOCKS);
  localparam int LW = $clog2(DISK_BLOCKS + 1);
  localparam int FW = $clog2(MAX_FILES + 1);
  localparam int XW = (LW > IDX_W) ? LW : IDX_W;
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam int LIMIT_RST =
    (BLOCKS_IN_USE_RST > DISK_BLOCKS) ? DISK_BLOCKS : BLOCKS_IN_USE_RST;

  state_t             state_r, state_nxt;
  logic [LW-1:0]      limit_r;
  logic [LW-1:0]      ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]   found_r, found_nxt;
  logic [IDX_W-1:0]   ib_r, ib_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FW-1:0]      files_r, files_nxt;
  logic [STS_W-1:0]   resp_sts_r, resp_sts_nxt;
  logic [FNUM_W-1:0]  resp_file_r, resp_file_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic               ram_rdata;

  logic [CW-1:0]      cfg_ext;
  logic [LW-1:0]      cfg_limit;
  logic               can_emit;
  logic               idx_ok;
  logic               table_full;
  logic               cnt_big;
  logic               hit;
  logic               issue_ok;
  logic               found_done;
  logic               grant_fire;
  logic               map_walk;
  logic               grant_last;

  // Block-use map: one bit per disk block, set when owned
  iba_ram #(
    .WIDTH (1),
    .DEPTH (DISK_BLOCKS)
  ) u_use_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturate the written block count to the disk size
  assign cfg_ext   = CW'(cfg_wr_data);
  assign cfg_limit = (cfg_ext > CW'(DISK_BLOCKS)) ? LW'(DISK_BLOCKS) : LW'(cfg_wr_data);

  // Shared status terms
  assign can_emit   = !out_valid_r || !out_stall;
  assign idx_ok     = (XW'(ib_r) < XW'(limit_r)) && !ram_rdata;
  assign table_full = (files_r == FW'(MAX_FILES));
  assign cnt_big    = (cnt_r > CNT_W'(MAX_FILE_BLOCKS));
  assign hit        = pend_r && !ram_rdata && (XW'(pend_addr_r) != XW'(ib_r));
  assign issue_ok   = (ptr_r < limit_r);
  assign found_done = ((found_r + 1'b1) == cnt_r);
  assign grant_fire = (state_r == ST_GRANT) && hit && can_emit;
  assign map_walk   = (state_r == ST_SCAN) || (state_r == ST_GRANT);
  assign grant_last = grant_fire && found_done;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (ptr_r == LW'(DISK_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!idx_ok || table_full || cnt_big || (cnt_r == '0)) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (hit && found_done) begin
          state_nxt = ST_GRANT;
        end else if (!pend_r && !issue_ok) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_GRANT: begin
        if (grant_fire && found_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    found_nxt     = found_r;
    ib_nxt        = ib_r;
    cnt_nxt       = cnt_r;
    files_nxt     = files_r;
    resp_sts_nxt  = resp_sts_r;
    resp_file_nxt = resp_file_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = 1'b1;
    ram_raddr     = ptr_r[AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep every entry to free
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = 1'b0;
        ptr_nxt   = LW'(ptr_r + 1'b1);
      end
      ST_IDLE: begin
        // Read the requested index block as the word arrives
        ram_raddr = AW'(in_word.index_block);
        if (in_valid) begin
          ib_nxt  = in_word.index_block;
          cnt_nxt = in_word.block_count;
        end
      end
      ST_CHECK: begin
        ptr_nxt       = '0;
        pend_nxt      = 1'b0;
        found_nxt     = '0;
        resp_file_nxt = '0;
        priority if (!idx_ok) begin
          resp_sts_nxt = STS_INVALID;
        end else if (table_full) begin
          resp_sts_nxt = STS_FULL;
        end else if (cnt_big) begin
          resp_sts_nxt = STS_NOSPACE;
        end else if (cnt_r == '0) begin
          // Empty file: claim the index block only
          resp_sts_nxt  = STS_EMPTY;
          resp_file_nxt = FNUM_W'(files_r);
          files_nxt     = FW'(files_r + 1'b1);
          ram_we        = 1'b1;
          ram_waddr     = AW'(ib_r);
        end else begin
          resp_sts_nxt = STS_NOSPACE;
        end
      end
      ST_SCAN: begin
        // Count free blocks, claiming only the index block once enough are found
        if (hit) begin
          found_nxt = CNT_W'(found_r + 1'b1);
        end
        priority if (hit && found_done) begin
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = '0;
          ram_we    = 1'b1;
          ram_waddr = AW'(ib_r);
        end else if (issue_ok) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt       = LW'(ptr_r + 1'b1);
        end else begin
          pend_nxt      = 1'b0;
          resp_sts_nxt  = STS_NOSPACE;
          resp_file_nxt = '0;
        end
      end
      ST_GRANT: begin
        priority if (hit && !can_emit) begin
          // Hold the free block and read it again
          ram_raddr = pend_addr_r;
        end else begin
          if (hit) begin
            ram_we                    = 1'b1;
            out_valid_nxt             = 1'b1;
            out_word_nxt.status       = STS_GRANTED;
            out_word_nxt.block_number = IDX_W'(pend_addr_r);
            out_word_nxt.file_number  = FNUM_W'(files_r);
            out_word_nxt.last         = found_done;
            found_nxt                 = CNT_W'(found_r + 1'b1);
          end
          priority if (hit && found_done) begin
            files_nxt = FW'(files_r + 1'b1);
            pend_nxt  = 1'b0;
          end else if (issue_ok) begin
            pend_nxt      = 1'b1;
            pend_addr_nxt = ptr_r[AW-1:0];
            ptr_nxt       = LW'(ptr_r + 1'b1);
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end
      ST_RESP: begin
        // Emit the single result word
        if (can_emit) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = resp_sts_r;
          out_word_nxt.block_number = '0;
          out_word_nxt.file_number  = resp_file_r;
          out_word_nxt.last         = 1'b1;
        end
      end
      default: begin
        ptr_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= '0;
      files_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LW'(LIMIT_RST);
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      files_r     <= files_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_limit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    ib_r        <= ib_nxt;
    cnt_r       <= cnt_nxt;
    resp_sts_r  <= resp_sts_nxt;
    resp_file_r <= resp_file_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  `IBA_ASSERT_IMP(a_found_below_cnt, clk, rst_n, map_walk, found_r < cnt_r)
  `IBA_ASSERT_IMP(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, in_stall && !out_valid_r)
  `IBA_ASSERT_NXT(a_file_count_step, clk, rst_n, grant_last, files_r == $past(files_r) + 1'b1)

endmodule

@@ hw/rtl/iba_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module iba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
